// ===== rtl/core/pte_pkg.sv =====
// Shared types and constants for the prefix trie engine.
`default_nettype none
package pte_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_PREFIX   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_LONG = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHILD,
    S_PCINC,
    S_NEXT,
    S_FINRD,
    S_RMPATH,
    S_RMSLOT,
    S_RMCH,
    S_RMDEC,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] letter;
    logic       last_letter;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] prefix_count;
    logic [1:0]  status;
  } out_t;

  // request as held in the queue, tagged with start-of-key
  typedef struct packed {
    in_t  req;
    logic first;
  } qitem_t;

  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

  // letters a..z; the letter field is sized for this
  localparam int          ALPHABET  = 26;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int unsigned ROOT_NODE = 1;

endpackage
`default_nettype wire

// ===== rtl/core/prefix_trie_engine.sv =====
// Prefix trie engine top level: request queue front end and trie walker back end.
// Usage:
//  - Requests carry one letter each on in_req_i (cmd, letter, last_letter) with
//    in_valid_i/in_ready_o; the cmd of a key's first letter governs the key.
//  - One result (found, prefix_count, status) per key leaves on out_res_o with
//    out_valid_o/out_ready_i once the key's last letter has been processed.
//  - Per letter the back end takes the letter from the queue, reads the child
//    table and steps; insert adds a pass-count read-modify-write, and once the
//    path is missing the child read is skipped. The child table has a single
//    read port. The last letter loads the result register, after an end-node
//    read for contains, prefix or remove; remove then decrements the pass count of
//    each path node and clears the word-end mark when no count reaches zero.
//  - A two-entry request queue lets the front end keep accepting while the
//    back end works or waits on the receiver.
//  - After reset a clearing pass over all NODES*ALPHABET child slots (26624 by
//    default) zeroes child links, pass counts and word-end marks; in_ready_o is low
//    throughout.
//  - When the receiver stalls, the result register holds; the back end stops
//    at its next result and the queue fills, after which in_ready_o drops.
`default_nettype none
module prefix_trie_engine #(
  parameter int NODES    = 1024,
  parameter int MAX_KEY  = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pte_pkg::in_t  in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pte_pkg::out_t      out_res_o
);
  pte_pkg::qhead_t head;
  logic            pop, busy;

  pte_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .busy_i(busy), .head_o(head), .pop_i(pop)
  );

  pte_back #(.NODES(NODES), .MAX_KEY(MAX_KEY)) u_back (
    .clk_i, .rst_ni, .head_i(head), .pop_o(pop), .busy_o(busy),
    .out_valid_o, .out_ready_i, .out_res_o
  );

endmodule
`default_nettype wire

// ===== rtl/core/pte_front.sv =====
// Front end: accepts requests, tags key starts, buffers them in a short queue.
`default_nettype none
module pte_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pte_pkg::in_t  in_req_i,
  input  wire logic          busy_i,
  output pte_pkg::qhead_t    head_o,
  input  wire logic          pop_i
);
  localparam int QD = 2;

  pte_pkg::qitem_t  fifo_q [QD];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             first_q;
  logic             push;

  assign in_ready_o = (cnt_q < 2'(QD)) && !busy_i;
  assign push       = in_valid_i && in_ready_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{req: in_req_i, first: first_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      cnt_q   <= 2'd0;
      first_q <= 1'b1;
    end else begin
      if (push) begin
        wptr_q  <= ~wptr_q;
        first_q <= in_req_i.last_letter;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pte_back.sv =====
// Back end: walks the trie stores for each queued request and builds results.
`default_nettype none
module pte_back #(
  parameter int NODES    = 1024,
  parameter int MAX_KEY  = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pte_pkg::qhead_t head_i,
  output logic                 pop_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output pte_pkg::out_t        out_res_o
);
  localparam int NW    = $clog2(NODES);
  localparam int SLOTS = NODES * pte_pkg::ALPHABET;
  localparam int SW    = $clog2(SLOTS);
  localparam int KW    = $clog2(MAX_KEY + 2);
  localparam int AW    = $clog2(MAX_KEY);
  localparam int PW    = NW + 5;

  function automatic logic [SW-1:0] slot_of(logic [NW-1:0] node, logic [4:0] ltr);
    return SW'(node) * SW'(pte_pkg::ALPHABET) + SW'(ltr);
  endfunction

  // stores
  logic [NW-1:0] child_mem [SLOTS];
  logic [15:0]   pass_mem  [NODES];
  logic          wend_mem  [NODES];
  logic [PW-1:0] walk_mem  [MAX_KEY];

  logic          ch_we;  logic [SW-1:0] ch_wa, ch_ra; logic [NW-1:0] ch_wd, ch_rd_q;
  logic          pc_we;  logic [NW-1:0] pc_wa, pc_ra; logic [15:0]   pc_wd, pc_rd_q;
  logic          we_we;  logic [NW-1:0] we_wa, we_ra; logic          we_wd, we_rd_q;
  logic          wk_we;  logic [AW-1:0] wk_wa, wk_ra; logic [PW-1:0] wk_wd, wk_rd_q;

  always_ff @(posedge clk_i) begin
    if (ch_we) child_mem[ch_wa] <= ch_wd;
    ch_rd_q <= child_mem[ch_ra];
  end
  always_ff @(posedge clk_i) begin
    if (pc_we) pass_mem[pc_wa] <= pc_wd;
    pc_rd_q <= pass_mem[pc_ra];
  end
  always_ff @(posedge clk_i) begin
    if (we_we) wend_mem[we_wa] <= we_wd;
    we_rd_q <= wend_mem[we_ra];
  end
  always_ff @(posedge clk_i) begin
    if (wk_we) walk_mem[wk_wa] <= wk_wd;
    wk_rd_q <= walk_mem[wk_ra];
  end

  pte_pkg::state_e state_q, state_d;
  logic [SW-1:0]   clr_q, clr_d, slot_q, slot_d;
  pte_pkg::cmd_e   cmd_q, cmd_d;
  logic [NW-1:0]   cur_q, cur_d, nfn_q, nfn_d, ch_q, ch_d;
  logic            miss_q, miss_d, ovf_q, ovf_d, full_q, full_d, last_q, last_d;
  logic [KW-1:0]   klen_q, klen_d, idx_q, idx_d;
  pte_pkg::out_t   res_q, res_d, out_q;
  logic            out_valid_q, out_load;

  // scratch
  pte_pkg::cmd_e   cmd_n;
  logic [NW-1:0]   cur_n, newc, par;
  logic            miss_n, ovf_n, full_n;
  logic [KW-1:0]   klen_n;
  logic [4:0]      let_s;
  logic [SW-1:0]   sl;
  logic [15:0]     newp;

  always_comb begin
    state_d = state_q; clr_d = clr_q; slot_d = slot_q; cmd_d = cmd_q;
    cur_d = cur_q; nfn_d = nfn_q; ch_d = ch_q; miss_d = miss_q; ovf_d = ovf_q;
    full_d = full_q; last_d = last_q; klen_d = klen_q; idx_d = idx_q; res_d = res_q;
    ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;
    pc_we = 1'b0; pc_wa = '0; pc_wd = '0; pc_ra = '0;
    we_we = 1'b0; we_wa = '0; we_wd = 1'b0; we_ra = '0;
    wk_we = 1'b0; wk_wa = '0; wk_wd = '0; wk_ra = '0;
    pop_o = 1'b0; out_load = 1'b0;
    cmd_n = cmd_q; cur_n = cur_q; miss_n = miss_q; ovf_n = ovf_q; full_n = full_q;
    klen_n = klen_q; newc = nfn_q + NW'(1); par = '0; let_s = '0; sl = '0; newp = '0;

    case (state_q)
      pte_pkg::S_CLEAR: begin
        ch_we = 1'b1; ch_wa = clr_q;
        if (32'(clr_q) < NODES) begin
          pc_we = 1'b1; pc_wa = clr_q[NW-1:0];
          we_we = 1'b1; we_wa = clr_q[NW-1:0];
        end
        clr_d = clr_q + SW'(1);
        if (clr_q == SW'(SLOTS - 1)) state_d = pte_pkg::S_IDLE;
      end
      pte_pkg::S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.first) begin
            cmd_n  = pte_pkg::cmd_e'(head_i.item.req.cmd);
            cur_n  = NW'(pte_pkg::ROOT_NODE);
            miss_n = 1'b0; ovf_n = 1'b0; full_n = 1'b0; klen_n = '0;
          end
          if (cmd_n == pte_pkg::CMD_REMOVE) begin
            if (klen_n < KW'(MAX_KEY)) begin
              wk_we = 1'b1; wk_wa = klen_n[AW-1:0];
              wk_wd = {cur_n, head_i.item.req.letter};
            end else begin
              ovf_n = 1'b1;
            end
          end
          klen_d = (klen_n <= KW'(MAX_KEY)) ? klen_n + KW'(1) : klen_n;
          last_d = head_i.item.req.last_letter;
          state_d = pte_pkg::S_NEXT;
          if (!miss_n) begin
            if (32'(head_i.item.req.letter) >= pte_pkg::ALPHABET) begin
              miss_n = 1'b1;
            end else begin
              sl = slot_of(cur_n, head_i.item.req.letter);
              ch_ra = sl; slot_d = sl;
              state_d = pte_pkg::S_CHILD;
            end
          end
          cmd_d = cmd_n; cur_d = cur_n; miss_d = miss_n; ovf_d = ovf_n; full_d = full_n;
        end
      end
      pte_pkg::S_CHILD: begin
        state_d = pte_pkg::S_NEXT;
        newc = ch_rd_q;
        if (ch_rd_q == '0) begin
          if (cmd_q != pte_pkg::CMD_INSERT) begin
            miss_n = 1'b1;
          end else if ((NW+1)'(nfn_q) + (NW+1)'(1) >= (NW+1)'(NODES)) begin
            miss_n = 1'b1; full_d = 1'b1;
          end else begin
            newc = nfn_q + NW'(1);
            ch_we = 1'b1; ch_wa = slot_q; ch_wd = newc;
            nfn_d = newc;
          end
        end
        miss_d = miss_n;
        if (!miss_n) begin
          cur_d = newc;
          if (cmd_q == pte_pkg::CMD_INSERT) begin
            pc_ra = newc;
            state_d = pte_pkg::S_PCINC;
          end
        end
      end
      pte_pkg::S_PCINC: begin
        if (pc_rd_q != pte_pkg::COUNT_MAX) begin
          pc_we = 1'b1; pc_wa = cur_q; pc_wd = pc_rd_q + 16'd1;
        end
        state_d = pte_pkg::S_NEXT;
      end
      pte_pkg::S_NEXT: begin
        if (!last_q) begin
          state_d = pte_pkg::S_IDLE;
        end else begin
          res_d = '0;
          state_d = pte_pkg::S_EMIT;
          if (cmd_q == pte_pkg::CMD_INSERT) begin
            if (full_q) res_d.status = pte_pkg::ST_FULL;
            else if (!miss_q) begin
              we_we = 1'b1; we_wa = cur_q; we_wd = 1'b1;
            end
          end else if (cmd_q == pte_pkg::CMD_REMOVE && ovf_q) begin
            res_d.status = pte_pkg::ST_LONG;
          end else if (!miss_q) begin
            pc_ra = cur_q; we_ra = cur_q;
            state_d = pte_pkg::S_FINRD;
          end
        end
      end
      pte_pkg::S_FINRD: begin
        state_d = pte_pkg::S_EMIT;
        case (cmd_q)
          pte_pkg::CMD_CONTAINS: res_d.found = we_rd_q;
          pte_pkg::CMD_PREFIX:   res_d.prefix_count = pc_rd_q;
          pte_pkg::CMD_REMOVE: begin
            if (we_rd_q) begin
              res_d.found = 1'b1;
              idx_d = '0;
              state_d = pte_pkg::S_RMPATH;
            end
          end
          default: ;
        endcase
      end
      pte_pkg::S_RMPATH: begin
        if (idx_q < klen_q && idx_q < KW'(MAX_KEY)) begin
          wk_ra = idx_q[AW-1:0];
          state_d = pte_pkg::S_RMSLOT;
        end else begin
          we_we = 1'b1; we_wa = cur_q; we_wd = 1'b0;
          state_d = pte_pkg::S_EMIT;
        end
      end
      pte_pkg::S_RMSLOT: begin
        par = wk_rd_q[PW-1:5]; let_s = wk_rd_q[4:0];
        sl = slot_of(par, let_s);
        ch_ra = sl; slot_d = sl;
        state_d = pte_pkg::S_RMCH;
      end
      pte_pkg::S_RMCH: begin
        ch_d = ch_rd_q; pc_ra = ch_rd_q;
        state_d = pte_pkg::S_RMDEC;
      end
      pte_pkg::S_RMDEC: begin
        newp = (pc_rd_q != 16'd0) ? pc_rd_q - 16'd1 : 16'd0;
        pc_we = 1'b1; pc_wa = ch_q; pc_wd = newp;
        if (newp == 16'd0) begin
          ch_we = 1'b1; ch_wa = slot_q; ch_wd = '0;
          state_d = pte_pkg::S_EMIT;
        end else begin
          idx_d = idx_q + KW'(1);
          state_d = pte_pkg::S_RMPATH;
        end
      end
      pte_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1; klen_d = '0;
          state_d = pte_pkg::S_IDLE;
        end
      end
      default: state_d = pte_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d; cur_q <= cur_d; ch_q <= ch_d; res_q <= res_d;
    last_q <= last_d; idx_q <= idx_d;
    if (out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pte_pkg::S_CLEAR;
      clr_q       <= '0;
      cmd_q       <= pte_pkg::CMD_INSERT;
      nfn_q       <= NW'(pte_pkg::ROOT_NODE);
      miss_q      <= 1'b0;
      ovf_q       <= 1'b0;
      full_q      <= 1'b0;
      klen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cmd_q   <= cmd_d;
      nfn_q   <= nfn_d;
      miss_q  <= miss_d;
      ovf_q   <= ovf_d;
      full_q  <= full_d;
      klen_q  <= klen_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign busy_o      = (state_q == pte_pkg::S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pte_pkg::S_CLEAR |-> !out_valid_q) else $error("result during clear");
  a_nfn_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfn_q != '0) else $error("node counter wrapped");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == pte_pkg::S_IDLE && head_i.valid) else $error("bad pop");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_ready_i) else $error("result overwritten");

endmodule
`default_nettype wire

// ===== bench/tb_prefix_trie_engine.sv =====
// Self-checking testbench for the prefix trie engine: directed keys, then random traffic.
`timescale 1ns / 100ps
module tb_prefix_trie_engine;

  localparam int NODES    = 1024;
  localparam int ALPHA    = pte_pkg::ALPHABET;
  localparam int MAX_KEY  = 32;
  localparam int IDLE_MAX = 200000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  pte_pkg::in_t  in_req_i;
  pte_pkg::out_t out_res_o;

  prefix_trie_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_res_o(out_res_o)
  );

  // trie shadow
  int unsigned trie_child [NODES*ALPHA];
  int unsigned trie_pass  [NODES];
  bit          trie_word  [NODES];
  int unsigned free_node, cur_node, key_len;
  bit          miss, overflow, full;
  pte_pkg::cmd_e key_cmd;
  int unsigned rm_parent [MAX_KEY];
  int unsigned rm_letter [MAX_KEY];

  pte_pkg::out_t expected_results [$];
  int   errors;
  bit   no_gaps;      // sender and receiver both run flat out
  bit   long_hold;    // receiver holds off for a long stretch once
  int   idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void trie_reset();
    foreach (trie_child[i]) trie_child[i] = 0;
    foreach (trie_pass[i]) trie_pass[i] = 0;
    foreach (trie_word[i]) trie_word[i] = 1'b0;
    free_node = pte_pkg::ROOT_NODE;
    cur_node  = pte_pkg::ROOT_NODE;
    key_len   = 0;
    miss      = 1'b0;
    overflow  = 1'b0;
    full      = 1'b0;
    key_cmd   = pte_pkg::CMD_INSERT;
  endfunction

  // unwinds a removed word; stops at the first node whose count drops to zero
  function automatic void trie_unlink();
    int unsigned s, ch;
    for (int i = 0; i < key_len && i < MAX_KEY; i++) begin
      s  = rm_parent[i] * ALPHA + (rm_letter[i] % ALPHA);
      ch = trie_child[s] % NODES;
      if (trie_pass[ch] > 0) trie_pass[ch]--;
      if (trie_pass[ch] == 0) begin
        trie_child[s] = 0;
        return;
      end
    end
    trie_word[cur_node] = 1'b0;
  endfunction

  function automatic bit trie_apply(pte_pkg::in_t r, output pte_pkg::out_t res);
    int unsigned s;
    res = '0;
    if (key_len == 0) begin
      key_cmd  = pte_pkg::cmd_e'(r.cmd);
      cur_node = pte_pkg::ROOT_NODE;
      miss     = 1'b0;
      overflow = 1'b0;
      full     = 1'b0;
    end
    if (key_cmd == pte_pkg::CMD_REMOVE) begin
      if (key_len < MAX_KEY) begin
        rm_parent[key_len] = cur_node % NODES;
        rm_letter[key_len] = r.letter;
      end else overflow = 1'b1;
    end
    if (!miss) begin
      if (r.letter >= ALPHA) miss = 1'b1;
      else begin
        s = (cur_node % NODES) * ALPHA + r.letter;
        if (trie_child[s] == 0) begin
          if (key_cmd != pte_pkg::CMD_INSERT) miss = 1'b1;
          else if (free_node + 1 >= NODES) begin
            miss = 1'b1;
            full = 1'b1;
          end else begin
            free_node++;
            trie_child[s] = free_node;
          end
        end
        if (!miss) begin
          cur_node = trie_child[s] % NODES;
          if (key_cmd == pte_pkg::CMD_INSERT && trie_pass[cur_node] < pte_pkg::COUNT_MAX)
            trie_pass[cur_node]++;
        end
      end
    end
    if (key_len <= MAX_KEY) key_len++;
    if (!r.last_letter) return 1'b0;
    case (key_cmd)
      pte_pkg::CMD_INSERT: begin
        if (full) res.status = pte_pkg::ST_FULL;
        else if (!miss) trie_word[cur_node] = 1'b1;
      end
      pte_pkg::CMD_REMOVE: begin
        if (overflow) res.status = pte_pkg::ST_LONG;
        else if (!miss && trie_word[cur_node]) begin
          res.found = 1'b1;
          trie_unlink();
        end
      end
      pte_pkg::CMD_CONTAINS: res.found = !miss && trie_word[cur_node];
      default: res.prefix_count = miss ? 16'd0 : 16'(trie_pass[cur_node]);
    endcase
    key_len = 0;
    return 1'b1;
  endfunction

  task automatic send_req(pte_pkg::cmd_e c, logic [4:0] letter, logic last);
    int   gap;
    pte_pkg::in_t  r;
    pte_pkg::out_t res;
    r   = '{cmd: c, letter: letter, last_letter: last};
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (trie_apply(r, res)) expected_results = {expected_results, res};
  endtask

  task automatic send_word(pte_pkg::cmd_e c, string w);
    for (int i = 0; i < w.len(); i++)
      send_req(c, 5'(w[i] - "a"), i == w.len() - 1);
  endtask

  task automatic test_basic();
    send_word(pte_pkg::CMD_INSERT, "a");
    send_word(pte_pkg::CMD_INSERT, "az");
    send_word(pte_pkg::CMD_CONTAINS, "a");
    send_word(pte_pkg::CMD_CONTAINS, "az");
    send_word(pte_pkg::CMD_CONTAINS, "z");
    send_word(pte_pkg::CMD_PREFIX, "a");
    send_word(pte_pkg::CMD_REMOVE, "az");
    send_word(pte_pkg::CMD_CONTAINS, "az");
    send_word(pte_pkg::CMD_REMOVE, "az");
    send_word(pte_pkg::CMD_PREFIX, "a");
  endtask

  task automatic test_odd_keys();
    send_req(pte_pkg::CMD_INSERT, 5'd3, 1'b0);   // out-of-range letter mid insert
    send_req(pte_pkg::CMD_INSERT, 5'd31, 1'b0);
    send_req(pte_pkg::CMD_INSERT, 5'd4, 1'b1);
    send_req(pte_pkg::CMD_PREFIX, 5'd3, 1'b1);
    send_req(pte_pkg::CMD_CONTAINS, 5'd26, 1'b1);
    send_req(pte_pkg::CMD_INSERT, 5'd1, 1'b0);   // later cmd ignored
    send_req(pte_pkg::CMD_PREFIX, 5'd2, 1'b1);
    send_word(pte_pkg::CMD_INSERT, "bc");         // duplicate insert
    send_word(pte_pkg::CMD_PREFIX, "bc");
    send_word(pte_pkg::CMD_REMOVE, "bc");
    send_word(pte_pkg::CMD_CONTAINS, "bc");
  endtask

  task automatic test_random(int n_items);
    string pool [12];
    int    sent, len, pick, hold_at;
    pte_pkg::cmd_e c;
    string w;
    foreach (pool[i]) begin
      len = $urandom_range(1, 5);
      pool[i] = "";
      for (int j = 0; j < len; j++) pool[i] = {pool[i], string'(8'("a" + $urandom_range(0, 3)))};
    end
    sent = 0;
    hold_at = n_items / 2;
    while (sent < n_items) begin
      if (sent >= hold_at && hold_at > 0) begin
        long_hold = 1'b1;
        no_gaps   = 1'b1;   // keep offering so the queue backs up
        hold_at   = 0;
      end else if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
      c    = pte_pkg::cmd_e'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        w = pool[$urandom_range(0, 11)];
        send_word(c, w);
        sent += w.len();
      end else if (pick < 97) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++)
          send_req(j == 0 || $urandom_range(0, 7) != 0 ? c : pte_pkg::cmd_e'($urandom_range(0, 3)),
                   $urandom_range(0, 31) < 29 ? 5'($urandom_range(0, 25)) : 5'($urandom),
                   j == len - 1);
        sent += len;
      end else begin
        // key past the path buffer
        len = $urandom_range(MAX_KEY + 1, MAX_KEY + 4);
        for (int j = 0; j < len; j++)
          send_req($urandom_range(0, 1) ? pte_pkg::CMD_REMOVE : c, 5'($urandom_range(0, 3)),
                   j == len - 1);
        sent += len;
      end
    end
    no_gaps = 1'b0;
  endtask

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int n;
    out_ready_i = 1'b0;
    forever begin
      n = long_hold ? 400 : (no_gaps ? 0 : $urandom_range(0, 7));
      long_hold = 1'b0;
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    pte_pkg::out_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_res_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_res_o.found !== e.found) begin
          $error("found: expected %0d, actual %0d", e.found, out_res_o.found);
          errors++;
        end
        if (out_res_o.prefix_count !== e.prefix_count) begin
          $error("prefix_count: expected %0d, actual %0d", e.prefix_count,
                 out_res_o.prefix_count);
          errors++;
        end
        if (out_res_o.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_res_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("prefix_trie_engine verification failed");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    no_gaps     = 1'b0;
    long_hold   = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    rst_ni      = 1'b0;
    trie_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic();
    test_odd_keys();
    test_random(920);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("prefix_trie_engine verification clean");
    end else begin
      $display("prefix_trie_engine verification failed");
    end
    $finish;
  end

endmodule
